### sv/bpe_pkg.sv
// Package for the Bezier point evaluator: sizes, point type, codes and
// the command struct between controller and datapath. No dependencies.
package bpe_pkg;

    localparam int MAX_POINTS  = 7;
    localparam int COORD_WIDTH = 16;
    localparam int MIN_POINTS  = 2;

    localparam int T_WIDTH = 17;
    localparam int T_SHIFT = 16;
    localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1 << T_SHIFT);

    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int PC_W       = $clog2(MAX_POINTS + 1);
    localparam int CFG_IDX_W  = $clog2(MAX_POINTS + 1);
    localparam int CFG_DATA_W = 3 * COORD_WIDTH;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] x;
    } t_point;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT = CFG_IDX_W'(0),
        CFG_POINT_BASE  = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             last;
        logic [IDX_W-1:0] wr_idx;
        logic             out_load;
        logic             out_ok;
    } t_cmd;

endpackage

### sv/bpe_cfg_regs.sv
// Configuration registers of the Bezier point evaluator: point count and
// control points. Depends on bpe_pkg.
module bpe_cfg_regs
    import bpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [PC_W-1:0]       o_point_count,
    output t_point [MAX_POINTS-1:0] o_points
);

    logic [PC_W-1:0]         r_point_count;
    t_point [MAX_POINTS-1:0] r_points;
    logic [CFG_IDX_W-1:0]    pt_sel;

    assign pt_sel = i_cfg_index - CFG_POINT_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_points      <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_POINT_COUNT) begin
                r_point_count <= i_cfg_data[PC_W-1:0];
            end else if (32'(i_cfg_index) <= MAX_POINTS) begin
                r_points[pt_sel[IDX_W-1:0]] <= t_point'(i_cfg_data);
            end
        end
    end

    assign o_point_count = r_point_count;
    assign o_points      = r_points;

endmodule

### sv/bpe_ctrl.sv
// Controller of the Bezier point evaluator: sequences the lerp rounds and
// owns both handshakes. Depends on bpe_pkg.
module bpe_ctrl
    import bpe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    input  logic [PC_W-1:0] i_point_count,
    output t_cmd            o_cmd
);

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_len, n_len;
    logic [PC_W-1:0] r_left, n_left;
    logic            r_ok, n_ok;
    logic            r_out_valid, n_out_valid;
    logic [PC_W-1:0] pts_used;

    assign pts_used = (i_point_count > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS)
                                                          : i_point_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_left      <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_left      <= n_left;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_left      = r_left;
        n_ok        = r_ok;
        // drop the result once the receiver takes it
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        o_cmd.out_ok = r_ok;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_len      = pts_used;
                    n_left     = pts_used - PC_W'(1);
                    if (pts_used < PC_W'(MIN_POINTS)) begin
                        n_ok    = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (r_left == PC_W'(1)) begin
                    // last lerp of a round: the queue shrinks by one
                    o_cmd.last   = 1'b1;
                    o_cmd.wr_idx = IDX_W'(r_len - PC_W'(2));
                    if (r_len == PC_W'(MIN_POINTS)) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_len  = r_len - PC_W'(1);
                        n_left = r_len - PC_W'(2);
                    end
                end else begin
                    o_cmd.wr_idx = IDX_W'(r_len - PC_W'(1));
                    n_left       = r_left - PC_W'(1);
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/bpe_datapath.sv
// Datapath of the Bezier point evaluator: point queue, shared 3-component
// lerp unit and result register. Depends on bpe_pkg.
module bpe_datapath
    import bpe_pkg::*;
(
    input  logic                          i_clk,
    input  t_cmd                          i_cmd,
    input  logic [T_WIDTH-1:0]            i_curve_param,
    input  t_point [MAX_POINTS-1:0]       i_points,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_point_valid
);

    localparam int PROD_W = COORD_WIDTH + T_WIDTH + 2;

    t_point [MAX_POINTS-1:0] r_q, n_q;
    logic [T_WIDTH-1:0]      r_t;
    t_point                  r_out;
    logic                    r_out_ok;
    t_point                  lerp_res;

    // a + floor((b - a) * t / 2^16); result always lies between a and b
    function automatic logic signed [COORD_WIDTH-1:0] lerp1(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b,
        input logic [T_WIDTH-1:0]            t
    );
        logic signed [COORD_WIDTH:0] d;
        logic signed [PROD_W-1:0]    p;
        logic signed [PROD_W-1:0]    s;
        d = (COORD_WIDTH+1)'(b) - (COORD_WIDTH+1)'(a);
        p = PROD_W'(d) * PROD_W'(signed'({1'b0, t}));
        s = PROD_W'(a) + (p >>> T_SHIFT);
        return s[COORD_WIDTH-1:0];
    endfunction

    assign lerp_res.x = lerp1(r_q[0].x, r_q[1].x, r_t);
    assign lerp_res.y = lerp1(r_q[0].y, r_q[1].y, r_t);
    assign lerp_res.z = lerp1(r_q[0].z, r_q[1].z, r_t);

    always_comb begin
        n_q = r_q;
        if (i_cmd.load) begin
            n_q = i_points;
        end else if (i_cmd.step) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (i_cmd.last) begin
                    n_q[k] = (k + 2 < MAX_POINTS) ? r_q[(k + 2) % MAX_POINTS] : r_q[k];
                end else begin
                    n_q[k] = (k + 1 < MAX_POINTS) ? r_q[(k + 1) % MAX_POINTS] : r_q[k];
                end
                if (IDX_W'(k) == i_cmd.wr_idx) begin
                    n_q[k] = lerp_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (i_cmd.load) begin
            r_t <= (i_curve_param > T_ONE) ? T_ONE : i_curve_param;
        end
        if (i_cmd.out_load) begin
            r_out    <= i_cmd.out_ok ? r_q[0] : '0;
            r_out_ok <= i_cmd.out_ok;
        end
    end

    assign o_out_x       = r_out.x;
    assign o_out_y       = r_out.y;
    assign o_out_z       = r_out.z;
    assign o_point_valid = r_out_ok;

endmodule

### sv/bezier_point_evaluator_top.sv
// Top level of the Bezier point evaluator (de Casteljau, fixed point).
// Depends on bpe_pkg, bpe_cfg_regs, bpe_ctrl and bpe_datapath.
// Configuration: write point_count at index 0 and control points 0..6 at
//   indices 1..7 (z in bits 47..32, y in 31..16, x in 15..0, signed).
//   o_cfg_ready is always high; write only while no request is in flight.
// Input: a request carries curve parameter t (Q1.16, values above 1.0 clamp
//   to 1.0). It is taken when i_in_valid is high and o_in_stall low.
// Output: one result per request (x, y, z, point_valid), taken when
//   o_out_valid is high and i_out_stall low. With fewer than two points the
//   result is all zero and point_valid is low.
// Sequence: the shared lerp unit does one x/y/z lerp per cycle, so n points
//   need n*(n-1)/2 lerps in the run state (none for fewer than two points);
//   the finish step then loads the result register and returns to idle.
//   A request is taken only in idle, so the next one waits until the
//   current result has been loaded.
// Stall: the result register decouples the sides, so a new request is taken
//   while a result still waits. If the receiver stalls, the next result holds
//   in the finish step until the register frees up.
// Reset: synchronous, active low; clears the configuration and the
//   controller, leaving the block idle with no result pending.
module bezier_point_evaluator_top
    import bpe_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [T_WIDTH-1:0]            i_curve_param,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_point_valid,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic [PC_W-1:0]         point_count;
    t_point [MAX_POINTS-1:0] points;
    t_cmd                    cmd;

    // config writes are never stalled
    assign o_cfg_ready = 1'b1;

    bpe_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_point_count (point_count),
        .o_points      (points)
    );

    bpe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .i_point_count (point_count),
        .o_cmd         (cmd)
    );

    bpe_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_curve_param (i_curve_param),
        .i_points      (points),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_point_valid (o_point_valid)
    );

    // an accepted request keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but input side not busy");

    // load, lerp step and result load never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // a result shows up only after the result register was loaded
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("result valid without result load");

endmodule
